[hdl/radial_tangential_lens_distort_top_assert.svh]
// assertion helpers for the top-level rtl file
`ifndef RADIAL_TANGENTIAL_LENS_DISTORT_TOP_ASSERT_SVH
`define RADIAL_TANGENTIAL_LENS_DISTORT_TOP_ASSERT_SVH

`ifndef SYNTH
`define RTLD_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rtld assertion failed");
`define RTLD_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rtld assertion failed");
`else
`define RTLD_ASSERT_IMP(lbl, ante, cons)
`define RTLD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[hdl/rtld_pkg.sv]
package rtld_pkg;

   localparam int QW = 63;   // intermediate, signed Q.32 held within +-(2^62 - 1)
   localparam int OW = 48;   // output, signed Q16.32
   localparam int CW = 32;   // coefficient and point words

   typedef logic signed [QW-1:0] qv_type;
   typedef logic signed [QW+3:0] qwide_type;
   typedef logic signed [OW-1:0] ov_type;

   localparam qv_type QLIM = {1'b0, {(QW-1){1'b1}}};
   localparam qv_type QONE = qv_type'(64'h1_0000_0000);
   localparam ov_type OMAX = {1'b0, {(OW-1){1'b1}}};
   localparam ov_type OMIN = {1'b1, {(OW-1){1'b0}}};

   typedef enum logic [2:0] {
      RK_POINT = 3'd0,
      RK_DX    = 3'd1,
      RK_DY    = 3'd2,
      RK_K1    = 3'd3,
      RK_K2    = 3'd4,
      RK_P1    = 3'd5,
      RK_P2    = 3'd6,
      RK_K3    = 3'd7
   } row_kind_type;

   typedef enum logic [2:0] {
      CSR_K1 = 3'd0,
      CSR_K2 = 3'd1,
      CSR_K3 = 3'd2,
      CSR_P1 = 3'd3,
      CSR_P2 = 3'd4
   } csr_index_type;

   function automatic qv_type q_sat(input qwide_type w);
      qv_type r;
      if (w > qwide_type'(QLIM)) begin
         r = QLIM;
      end else if (w < -qwide_type'(QLIM)) begin
         r = -QLIM;
      end else begin
         r = qv_type'(w);
      end
      return r;
   endfunction

   function automatic qv_type q_add(input qv_type a, input qv_type b);
      return q_sat(qwide_type'(a) + qwide_type'(b));
   endfunction

   function automatic qv_type q_dbl(input qv_type a);
      return q_sat(qwide_type'(a) <<< 1);
   endfunction

   function automatic qv_type q_quad(input qv_type a);
      return q_sat(qwide_type'(a) <<< 2);
   endfunction

   function automatic qv_type q_six(input qv_type a);
      return q_sat((qwide_type'(a) <<< 2) + (qwide_type'(a) <<< 1));
   endfunction

   function automatic ov_type q_out(input qv_type a);
      ov_type r;
      if (a > qv_type'(OMAX)) begin
         r = OMAX;
      end else if (a < qv_type'(OMIN)) begin
         r = OMIN;
      end else begin
         r = ov_type'(a);
      end
      return r;
   endfunction

   // Q4.28 point word to Q.32
   function automatic qv_type q_from_pt(input logic [CW-1:0] d);
      return qv_type'($signed(d)) <<< 4;
   endfunction

   // Q8.24 coefficient word to Q.32
   function automatic qv_type q_from_cf(input logic [CW-1:0] d);
      return qv_type'($signed(d)) <<< 8;
   endfunction

endpackage

[hdl/rtld_qmul.sv]
module rtld_qmul
   import rtld_pkg::*;
(
   input  logic   clock,
   input  logic   en,
   input  qv_type a,
   input  qv_type b,
   output qv_type p
);

   localparam int MW = QW - 1;        // magnitude bits
   localparam int HW = 32;            // low partial word
   localparam int UW = MW - HW;       // high partial word
   localparam int SW = 2 * HW + 1;    // combine width
   localparam logic [2*HW-1:0] RND = (2*HW)'(1) << (HW - 1);

   logic [MW-1:0]     ua;
   logic [MW-1:0]     ub;
   logic [2*HW-1:0]   lo_in, lo_ff;
   logic [MW-1:0]     m1_in, m1_ff;
   logic [MW-1:0]     m2_in, m2_ff;
   logic [2*UW-1:0]   hi_in, hi_ff;
   logic              neg_in, neg_ff;
   logic [SW-1:0]     mid;
   logic [SW-1:0]     q;
   qv_type            mag;

   // split magnitudes, four partial products
   always_comb begin
      ua     = a[QW-1] ? MW'(-a) : MW'(a);
      ub     = b[QW-1] ? MW'(-b) : MW'(b);
      lo_in  = ua[HW-1:0] * ub[HW-1:0];
      m1_in  = ua[MW-1:HW] * ub[HW-1:0];
      m2_in  = ua[HW-1:0] * ub[MW-1:HW];
      hi_in  = ua[MW-1:HW] * ub[MW-1:HW];
      neg_in = a[QW-1] ^ b[QW-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff  <= lo_in;
         m1_ff  <= m1_in;
         m2_ff  <= m2_in;
         hi_ff  <= hi_in;
         neg_ff <= neg_in;
      end
   end

   // round half away from zero on the magnitude, then saturate and sign
   always_comb begin
      mid = SW'(m1_ff) + SW'(m2_ff) + SW'((lo_ff + RND) >> HW);
      q   = (SW'(hi_ff) << HW) + mid;
      if ((|hi_ff[2*UW-1:MW-HW]) || (q > SW'(QLIM))) begin
         mag = QLIM;
      end else begin
         mag = qv_type'(q);
      end
      p = neg_ff ? -mag : mag;
   end

endmodule

[hdl/radial_tangential_lens_distort_top.sv]
// Radial-tangential lens distortion of normalized points.
// Requests come in on the req_ stream: tdata holds point_x and point_y (Q4.28),
// tuser holds the two Jacobian request flags. Results leave on the rsp_ stream,
// one row per beat: tuser gives the row kind, tdata the u and v values (Q16.32,
// saturated), tlast marks the final row of a point.
// The five coefficients are written over the csr_ channel (index 0..4:
// k1, k2, k3, p1, p2); csr_ready is always high. Write them only while idle.
// Throughput: one request per cycle when only the point row is asked for and
// rsp_tready stays high; a request with more rows holds the result port until
// its last row is taken, and the input stalls behind it once the pipeline has
// filled. The pipeline depth is set by the chain of five multiplies (split into
// 32-bit and 30-bit partial products) needed for u, v and the Jacobian terms.
// Reset clears the pipeline valid bits, the output valid bit and row kind, and the coefficients.
// When rsp_tready is low the output row holds and the pipeline keeps filling
// its empty stages; every stage keeps its item until the next one has room.
`include "radial_tangential_lens_distort_top_assert.svh"

module radial_tangential_lens_distort_top
   import rtld_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // point_x [31:0], point_y [63:32]
   input  logic [1:0]  req_tuser,   // want_point_jacobian [0], want_coeff_jacobian [1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // value_u [47:0], value_v [95:48]
   output logic [2:0]  rsp_tuser,   // row_kind [2:0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int NS   = 16;
   localparam int NMUL = 32;
   localparam int NROW = 8;

   localparam int M_XX = 0, M_YY = 1, M_XY = 2, M_P1X = 3, M_P1Y = 4, M_P2X = 5, M_P2Y = 6;
   localparam int M_R4 = 7, M_K1R2 = 8, M_K2R2 = 9, M_XR2 = 10, M_YR2 = 11;
   localparam int M_P1XY2 = 12, M_P2XY2 = 13, M_P2TU = 14, M_P1TV = 15;
   localparam int M_R6 = 16, M_K2R4 = 17, M_K3R4 = 18, M_XR4 = 19, M_YR4 = 20;
   localparam int M_K3R6 = 21, M_XR6 = 22, M_YR6 = 23, M_XG = 24, M_YG = 25;
   localparam int M_XRAD = 26, M_YRAD = 27, M_XGX = 28, M_YGX = 29, M_XGY = 30, M_YGY = 31;

   typedef struct packed {
      logic   want_pt;
      logic   want_cf;
      qv_type x, y, xx, yy, xy, p1x, p1y, p2x, p2y;
      qv_type r2, xy2, sxx, syy, p1x2, p1y2, p1y6, p2x2, p2x6, p2y2, tu, tv;
      qv_type r4, k1r2, k2r2, xr2, yr2, p1xy2, p2xy2, p2tu, p1tv, ga, ra;
      qv_type r6, k2r4, k3r4, xr4, yr4, g, rb, k3r6, xr6, yr6, xg, yg, rad;
      qv_type xrad, yrad, xgx, ygx, xgy, ygy, u, v, dudx, dudy, dvdx, dvdy;
   } bundle_type;

   logic [CW-1:0] coeff_ff [5];
   qv_type        k1, k2, k3, p1, p2;

   bundle_type    stage_ff [NS];
   bundle_type    stage_in [NS];
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS-1:0] stage_en;

   qv_type        mul_a [NMUL];
   qv_type        mul_b [NMUL];
   qv_type        mul_p [NMUL];
   logic [NMUL-1:0] mul_en;

   ov_type        row_u_ff [NROW];
   ov_type        row_v_ff [NROW];
   row_kind_type  kind_ff;
   row_kind_type  kind_next;
   logic          out_valid_ff;
   logic          out_pt_ff;
   logic          out_cf_ff;
   logic          row_last;
   logic          out_load;

   // coefficient registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) begin
            coeff_ff[i] <= '0;
         end
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_K1:  coeff_ff[CSR_K1] <= csr_wdata;
            CSR_K2:  coeff_ff[CSR_K2] <= csr_wdata;
            CSR_K3:  coeff_ff[CSR_K3] <= csr_wdata;
            CSR_P1:  coeff_ff[CSR_P1] <= csr_wdata;
            CSR_P2:  coeff_ff[CSR_P2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign k1 = q_from_cf(coeff_ff[CSR_K1]);
   assign k2 = q_from_cf(coeff_ff[CSR_K2]);
   assign k3 = q_from_cf(coeff_ff[CSR_K3]);
   assign p1 = q_from_cf(coeff_ff[CSR_P1]);
   assign p2 = q_from_cf(coeff_ff[CSR_P2]);

   // stall chain: a stage moves when it is empty or the next one moves
   always_comb begin
      stage_en[NS-1] = !valid_ff[NS-1] || out_load;
      for (int s = NS - 2; s >= 0; s--) begin
         stage_en[s] = !valid_ff[s] || stage_en[s+1];
      end
   end

   assign req_tready = stage_en[0];
   assign valid_in   = {valid_ff[NS-2:0], req_tvalid};

   // multiplier operands; each product lands two stages after issue
   always_comb begin
      mul_a[M_XX]    = stage_ff[0].x;     mul_b[M_XX]    = stage_ff[0].x;
      mul_a[M_YY]    = stage_ff[0].y;     mul_b[M_YY]    = stage_ff[0].y;
      mul_a[M_XY]    = stage_ff[0].x;     mul_b[M_XY]    = stage_ff[0].y;
      mul_a[M_P1X]   = p1;                mul_b[M_P1X]   = stage_ff[0].x;
      mul_a[M_P1Y]   = p1;                mul_b[M_P1Y]   = stage_ff[0].y;
      mul_a[M_P2X]   = p2;                mul_b[M_P2X]   = stage_ff[0].x;
      mul_a[M_P2Y]   = p2;                mul_b[M_P2Y]   = stage_ff[0].y;
      mul_a[M_R4]    = stage_ff[3].r2;    mul_b[M_R4]    = stage_ff[3].r2;
      mul_a[M_K1R2]  = k1;                mul_b[M_K1R2]  = stage_ff[3].r2;
      mul_a[M_K2R2]  = k2;                mul_b[M_K2R2]  = stage_ff[3].r2;
      mul_a[M_XR2]   = stage_ff[3].x;     mul_b[M_XR2]   = stage_ff[3].r2;
      mul_a[M_YR2]   = stage_ff[3].y;     mul_b[M_YR2]   = stage_ff[3].r2;
      mul_a[M_P1XY2] = p1;                mul_b[M_P1XY2] = stage_ff[3].xy2;
      mul_a[M_P2XY2] = p2;                mul_b[M_P2XY2] = stage_ff[3].xy2;
      mul_a[M_P2TU]  = p2;                mul_b[M_P2TU]  = stage_ff[4].tu;
      mul_a[M_P1TV]  = p1;                mul_b[M_P1TV]  = stage_ff[4].tv;
      mul_a[M_R6]    = stage_ff[5].r4;    mul_b[M_R6]    = stage_ff[5].r2;
      mul_a[M_K2R4]  = k2;                mul_b[M_K2R4]  = stage_ff[5].r4;
      mul_a[M_K3R4]  = k3;                mul_b[M_K3R4]  = stage_ff[5].r4;
      mul_a[M_XR4]   = stage_ff[5].x;     mul_b[M_XR4]   = stage_ff[5].r4;
      mul_a[M_YR4]   = stage_ff[5].y;     mul_b[M_YR4]   = stage_ff[5].r4;
      mul_a[M_K3R6]  = k3;                mul_b[M_K3R6]  = stage_ff[7].r6;
      mul_a[M_XR6]   = stage_ff[7].x;     mul_b[M_XR6]   = stage_ff[7].r6;
      mul_a[M_YR6]   = stage_ff[7].y;     mul_b[M_YR6]   = stage_ff[7].r6;
      mul_a[M_XG]    = stage_ff[8].x;     mul_b[M_XG]    = stage_ff[8].g;
      mul_a[M_YG]    = stage_ff[8].y;     mul_b[M_YG]    = stage_ff[8].g;
      mul_a[M_XRAD]  = stage_ff[10].x;    mul_b[M_XRAD]  = stage_ff[10].rad;
      mul_a[M_YRAD]  = stage_ff[10].y;    mul_b[M_YRAD]  = stage_ff[10].rad;
      mul_a[M_XGX]   = stage_ff[10].x;    mul_b[M_XGX]   = stage_ff[10].xg;
      mul_a[M_YGX]   = stage_ff[10].y;    mul_b[M_YGX]   = stage_ff[10].xg;
      mul_a[M_XGY]   = stage_ff[10].x;    mul_b[M_XGY]   = stage_ff[10].yg;
      mul_a[M_YGY]   = stage_ff[10].y;    mul_b[M_YGY]   = stage_ff[10].yg;

      for (int i = M_XX; i <= M_P2Y; i++)    mul_en[i] = stage_en[1];
      for (int i = M_R4; i <= M_P2XY2; i++)  mul_en[i] = stage_en[4];
      for (int i = M_P2TU; i <= M_P1TV; i++) mul_en[i] = stage_en[5];
      for (int i = M_R6; i <= M_YR4; i++)    mul_en[i] = stage_en[6];
      for (int i = M_K3R6; i <= M_YR6; i++)  mul_en[i] = stage_en[8];
      for (int i = M_XG; i <= M_YG; i++)     mul_en[i] = stage_en[9];
      for (int i = M_XRAD; i <= M_YGY; i++)  mul_en[i] = stage_en[11];
   end

   for (genvar i = 0; i < NMUL; i++) begin : g_mul
      rtld_qmul u_mul (
         .clock (clock),
         .en    (mul_en[i]),
         .a     (mul_a[i]),
         .b     (mul_b[i]),
         .p     (mul_p[i])
      );
   end

   // per-stage datapath
   always_comb begin
      stage_in[0]         = '0;
      stage_in[0].x       = q_from_pt(req_tdata[31:0]);
      stage_in[0].y       = q_from_pt(req_tdata[63:32]);
      stage_in[0].want_pt = req_tuser[0];
      stage_in[0].want_cf = req_tuser[1];
      for (int s = 1; s < NS; s++) begin
         stage_in[s] = stage_ff[s-1];
      end

      stage_in[2].xx  = mul_p[M_XX];
      stage_in[2].yy  = mul_p[M_YY];
      stage_in[2].xy  = mul_p[M_XY];
      stage_in[2].p1x = mul_p[M_P1X];
      stage_in[2].p1y = mul_p[M_P1Y];
      stage_in[2].p2x = mul_p[M_P2X];
      stage_in[2].p2y = mul_p[M_P2Y];

      stage_in[3].r2   = q_add(stage_ff[2].xx, stage_ff[2].yy);
      stage_in[3].xy2  = q_dbl(stage_ff[2].xy);
      stage_in[3].sxx  = q_dbl(stage_ff[2].xx);
      stage_in[3].syy  = q_dbl(stage_ff[2].yy);
      stage_in[3].p1x2 = q_dbl(stage_ff[2].p1x);
      stage_in[3].p1y2 = q_dbl(stage_ff[2].p1y);
      stage_in[3].p1y6 = q_six(stage_ff[2].p1y);
      stage_in[3].p2x2 = q_dbl(stage_ff[2].p2x);
      stage_in[3].p2x6 = q_six(stage_ff[2].p2x);
      stage_in[3].p2y2 = q_dbl(stage_ff[2].p2y);

      stage_in[4].tu = q_add(stage_ff[3].r2, stage_ff[3].sxx);
      stage_in[4].tv = q_add(stage_ff[3].r2, stage_ff[3].syy);

      stage_in[5].r4    = mul_p[M_R4];
      stage_in[5].k1r2  = mul_p[M_K1R2];
      stage_in[5].k2r2  = mul_p[M_K2R2];
      stage_in[5].xr2   = mul_p[M_XR2];
      stage_in[5].yr2   = mul_p[M_YR2];
      stage_in[5].p1xy2 = mul_p[M_P1XY2];
      stage_in[5].p2xy2 = mul_p[M_P2XY2];

      stage_in[6].p2tu = mul_p[M_P2TU];
      stage_in[6].p1tv = mul_p[M_P1TV];
      stage_in[6].ga   = q_add(q_dbl(k1), q_quad(stage_ff[5].k2r2));
      stage_in[6].ra   = q_add(QONE, stage_ff[5].k1r2);

      stage_in[7].r6   = mul_p[M_R6];
      stage_in[7].k2r4 = mul_p[M_K2R4];
      stage_in[7].k3r4 = mul_p[M_K3R4];
      stage_in[7].xr4  = mul_p[M_XR4];
      stage_in[7].yr4  = mul_p[M_YR4];

      stage_in[8].g  = q_add(stage_ff[7].ga, q_six(stage_ff[7].k3r4));
      stage_in[8].rb = q_add(stage_ff[7].ra, stage_ff[7].k2r4);

      stage_in[9].k3r6 = mul_p[M_K3R6];
      stage_in[9].xr6  = mul_p[M_XR6];
      stage_in[9].yr6  = mul_p[M_YR6];

      stage_in[10].xg  = mul_p[M_XG];
      stage_in[10].yg  = mul_p[M_YG];
      stage_in[10].rad = q_add(stage_ff[9].rb, stage_ff[9].k3r6);

      stage_in[12].xrad = mul_p[M_XRAD];
      stage_in[12].yrad = mul_p[M_YRAD];
      stage_in[12].xgx  = mul_p[M_XGX];
      stage_in[12].ygx  = mul_p[M_YGX];
      stage_in[12].xgy  = mul_p[M_XGY];
      stage_in[12].ygy  = mul_p[M_YGY];

      stage_in[13].u    = q_add(stage_ff[12].xrad, stage_ff[12].p1xy2);
      stage_in[13].v    = q_add(stage_ff[12].yrad, stage_ff[12].p1tv);
      stage_in[13].dudx = q_add(stage_ff[12].rad, stage_ff[12].xgx);
      stage_in[13].dudy = q_add(stage_ff[12].xgy, stage_ff[12].p1x2);
      stage_in[13].dvdx = q_add(stage_ff[12].ygx, stage_ff[12].p1x2);
      stage_in[13].dvdy = q_add(stage_ff[12].rad, stage_ff[12].ygy);

      stage_in[14].u    = q_add(stage_ff[13].u, stage_ff[13].p2tu);
      stage_in[14].v    = q_add(stage_ff[13].v, stage_ff[13].p2xy2);
      stage_in[14].dudx = q_add(stage_ff[13].dudx, stage_ff[13].p1y2);
      stage_in[14].dudy = q_add(stage_ff[13].dudy, stage_ff[13].p2y2);
      stage_in[14].dvdx = q_add(stage_ff[13].dvdx, stage_ff[13].p2y2);
      stage_in[14].dvdy = q_add(stage_ff[13].dvdy, stage_ff[13].p1y6);

      stage_in[15].dudx = q_add(stage_ff[14].dudx, stage_ff[14].p2x6);
      stage_in[15].dvdy = q_add(stage_ff[14].dvdy, stage_ff[14].p2x2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (stage_en[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NS; s++) begin
         if (stage_en[s]) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   // output stage: one row per beat, in kind order
   always_comb begin
      kind_next = kind_ff;
      row_last  = 1'b0;
      case (kind_ff)
         RK_POINT: begin
            if (out_pt_ff) begin
               kind_next = RK_DX;
            end else if (out_cf_ff) begin
               kind_next = RK_K1;
            end else begin
               row_last = 1'b1;
            end
         end
         RK_DX: kind_next = RK_DY;
         RK_DY: begin
            if (out_cf_ff) begin
               kind_next = RK_K1;
            end else begin
               row_last = 1'b1;
            end
         end
         RK_K1:   kind_next = RK_K2;
         RK_K2:   kind_next = RK_P1;
         RK_P1:   kind_next = RK_P2;
         RK_P2:   kind_next = RK_K3;
         RK_K3:   row_last  = 1'b1;
         default: row_last  = 1'b1;
      endcase
   end

   assign out_load = !out_valid_ff || (rsp_tready && row_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         kind_ff      <= RK_POINT;
      end else if (out_load) begin
         out_valid_ff <= valid_ff[NS-1];
         kind_ff      <= RK_POINT;
      end else if (rsp_tready) begin
         kind_ff <= kind_next;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_pt_ff          <= stage_ff[NS-1].want_pt;
         out_cf_ff          <= stage_ff[NS-1].want_cf;
         row_u_ff[RK_POINT] <= q_out(stage_ff[NS-1].u);
         row_v_ff[RK_POINT] <= q_out(stage_ff[NS-1].v);
         row_u_ff[RK_DX]    <= q_out(stage_ff[NS-1].dudx);
         row_v_ff[RK_DX]    <= q_out(stage_ff[NS-1].dvdx);
         row_u_ff[RK_DY]    <= q_out(stage_ff[NS-1].dudy);
         row_v_ff[RK_DY]    <= q_out(stage_ff[NS-1].dvdy);
         row_u_ff[RK_K1]    <= q_out(stage_ff[NS-1].xr2);
         row_v_ff[RK_K1]    <= q_out(stage_ff[NS-1].yr2);
         row_u_ff[RK_K2]    <= q_out(stage_ff[NS-1].xr4);
         row_v_ff[RK_K2]    <= q_out(stage_ff[NS-1].yr4);
         row_u_ff[RK_P1]    <= q_out(stage_ff[NS-1].xy2);
         row_v_ff[RK_P1]    <= q_out(stage_ff[NS-1].tv);
         row_u_ff[RK_P2]    <= q_out(stage_ff[NS-1].tu);
         row_v_ff[RK_P2]    <= q_out(stage_ff[NS-1].xy2);
         row_u_ff[RK_K3]    <= q_out(stage_ff[NS-1].xr6);
         row_v_ff[RK_K3]    <= q_out(stage_ff[NS-1].yr6);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = row_last;
   assign rsp_tdata  = {row_v_ff[kind_ff], row_u_ff[kind_ff]};

   // an empty output stage must never hold the input off
   `RTLD_ASSERT_IMP(a_ready_when_empty, !out_valid_ff, req_tready)
   // rows of one point follow back to back and never restart at the point row
   `RTLD_ASSERT_NXT(a_rows_follow, rsp_tvalid && rsp_tready && !rsp_tlast,
                    rsp_tvalid && (rsp_tuser != RK_POINT))
   `RTLD_ASSERT_IMP(a_point_rows_requested,
                    rsp_tvalid && (kind_ff == RK_DX || kind_ff == RK_DY), out_pt_ff)
   `RTLD_ASSERT_IMP(a_coeff_rows_requested,
                    rsp_tvalid && kind_ff != RK_POINT && kind_ff != RK_DX && kind_ff != RK_DY,
                    out_cf_ff)

endmodule

[tb/tb_radial_tangential_lens_distort_top.sv]
`timescale 1ns / 1ps

module tb_radial_tangential_lens_distort_top
   import rtld_pkg::*;
();

   localparam int CYCLE_LIMIT = 300000;
   localparam int LONG_HOLD = 400;
   localparam logic [2:0] CSR_SPARE_LO = 3'd5;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;
   localparam longint FIX_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam longint FIX_ONE = 64'sh1_0000_0000;
   localparam longint OUT_HI = 64'sh7FFF_FFFF_FFFF;
   localparam longint OUT_LO = -64'sh8000_0000_0000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   radial_tangential_lens_distort_top uut (.*);

   typedef struct {
      row_kind_type kind;
      logic [47:0]  u;
      logic [47:0]  v;
      logic         last;
   } dist_row_type;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic        pt;
      logic        cf;
      logic        typed;
      logic [47:0] eu;
      logic [47:0] ev;
   } point_vec_type;

   dist_row_type rows_pending[$];
   logic [31:0]  coeff_word[5];
   int           errors = 0;
   int           cycles = 0;
   int           burst_left = 0;
   int           hold_asked = 0;
   int           hold_given = 0;
   int           hold_left = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------- fixed point arithmetic ----------------
   function automatic longint fix_clamp(input logic signed [127:0] w);
      if (w > FIX_LIM) return FIX_LIM;
      if (w < -FIX_LIM) return -FIX_LIM;
      return longint'(w);
   endfunction

   function automatic longint fix_add(input longint a, input longint b);
      logic signed [127:0] w;
      w = a;
      w = w + b;
      return fix_clamp(w);
   endfunction

   function automatic longint fix_scale(input longint a, input int n);
      logic signed [127:0] w;
      w = a;
      w = w * n;
      return fix_clamp(w);
   endfunction

   // rounded to nearest, ties away from zero, on magnitudes
   function automatic longint fix_mul(input longint a, input longint b);
      logic [127:0] ma, mb, pr;
      logic neg;
      neg = (a < 0) != (b < 0);
      ma = 128'(a < 0 ? -a : a);
      mb = 128'(b < 0 ? -b : b);
      pr = (ma * mb + 128'h8000_0000) >> 32;
      if (pr > 128'(FIX_LIM)) pr = 128'(FIX_LIM);
      return neg ? -longint'(pr[63:0]) : longint'(pr[63:0]);
   endfunction

   function automatic logic [47:0] fix_out(input longint a);
      if (a > OUT_HI) a = OUT_HI;
      if (a < OUT_LO) a = OUT_LO;
      return a[47:0];
   endfunction

   function automatic longint coeff_q(input int i);
      return longint'($signed(coeff_word[i])) * 256;
   endfunction

   task automatic push_row(input row_kind_type k, input longint u, input longint v);
      dist_row_type r;
      r.kind = k;
      r.u = fix_out(u);
      r.v = fix_out(v);
      r.last = 1'b0;
      rows_pending.push_back(r);
   endtask

   // expected rows of one distorted point
   task automatic distort_point(input point_vec_type p);
      longint x, y, k1, k2, k3, p1, p2;
      longint xx, yy, xy, r2, r4, r6, rad, xy2, tu, tv, u, v;
      longint g, gx, gy, p1x2, p2y2, dudx, dudy, dvdx, dvdy;
      int first;
      x = longint'($signed(p.x)) * 16;
      y = longint'($signed(p.y)) * 16;
      k1 = coeff_q(CSR_K1); k2 = coeff_q(CSR_K2); k3 = coeff_q(CSR_K3);
      p1 = coeff_q(CSR_P1); p2 = coeff_q(CSR_P2);
      xx = fix_mul(x, x); yy = fix_mul(y, y); xy = fix_mul(x, y);
      r2 = fix_add(xx, yy); r4 = fix_mul(r2, r2); r6 = fix_mul(r4, r2);
      rad = fix_add(fix_add(fix_add(FIX_ONE, fix_mul(k1, r2)), fix_mul(k2, r4)),
                    fix_mul(k3, r6));
      xy2 = fix_scale(xy, 2);
      tu = fix_add(r2, fix_scale(xx, 2));
      tv = fix_add(r2, fix_scale(yy, 2));
      u = fix_add(fix_add(fix_mul(x, rad), fix_mul(p1, xy2)), fix_mul(p2, tu));
      v = fix_add(fix_add(fix_mul(y, rad), fix_mul(p1, tv)), fix_mul(p2, xy2));
      first = rows_pending.size();
      push_row(RK_POINT, u, v);
      if (p.typed) begin
         rows_pending[first].u = p.eu;
         rows_pending[first].v = p.ev;
      end
      if (p.pt) begin
         g = fix_add(fix_add(fix_scale(k1, 2), fix_scale(fix_mul(k2, r2), 4)),
                     fix_scale(fix_mul(k3, r4), 6));
         gx = fix_mul(x, g); gy = fix_mul(y, g);
         p1x2 = fix_scale(fix_mul(p1, x), 2);
         p2y2 = fix_scale(fix_mul(p2, y), 2);
         dudx = fix_add(fix_add(fix_add(rad, fix_mul(x, gx)),
                        fix_scale(fix_mul(p1, y), 2)), fix_scale(fix_mul(p2, x), 6));
         dudy = fix_add(fix_add(fix_mul(x, gy), p1x2), p2y2);
         dvdx = fix_add(fix_add(fix_mul(y, gx), p1x2), p2y2);
         dvdy = fix_add(fix_add(fix_add(rad, fix_mul(y, gy)),
                        fix_scale(fix_mul(p1, y), 6)), fix_scale(fix_mul(p2, x), 2));
         push_row(RK_DX, dudx, dvdx);
         push_row(RK_DY, dudy, dvdy);
      end
      if (p.cf) begin
         push_row(RK_K1, fix_mul(x, r2), fix_mul(y, r2));
         push_row(RK_K2, fix_mul(x, r4), fix_mul(y, r4));
         push_row(RK_P1, xy2, tv);
         push_row(RK_P2, tu, xy2);
         push_row(RK_K3, fix_mul(x, r6), fix_mul(y, r6));
      end
      rows_pending[rows_pending.size() - 1].last = 1'b1;
   endtask

   // ---------------- result checking ----------------
   always @(posedge clock) begin
      dist_row_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rows_pending.size() == 0) begin
            $display("%0t: unexpected row kind %0d u %h v %h", $time, rsp_tuser,
                     rsp_tdata[47:0], rsp_tdata[95:48]);
            errors++;
         end else begin
            e = rows_pending.pop_front();
            if (rsp_tuser !== e.kind) begin
               $display("%0t: row_kind expected %0d actual %0d", $time, e.kind, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[47:0] !== e.u) begin
               $display("%0t: value_u (kind %0d) expected %h actual %h", $time, e.kind,
                        e.u, rsp_tdata[47:0]);
               errors++;
            end
            if (rsp_tdata[95:48] !== e.v) begin
               $display("%0t: value_v (kind %0d) expected %h actual %h", $time, e.kind,
                        e.v, rsp_tdata[95:48]);
               errors++;
            end
            if (rsp_tlast !== e.last) begin
               $display("%0t: last_row (kind %0d) expected %b actual %b", $time, e.kind,
                        e.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // ---------------- receiver stalls ----------------
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_given != hold_asked) begin
         hold_given <= hold_given + 1;
         hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         case ((cycles / 256) % 3)
            0: begin
               rsp_tready <= 1'b1;
            end
            1: begin
               rsp_tready <= ($urandom_range(2) != 0);
            end
            default: begin
               rsp_tready <= ((cycles % 7) < 4);
            end
         endcase
      end
   end

   // ---------------- stimulus ----------------
   task automatic send_point(input point_vec_type p);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {p.y, p.x};
      req_tuser <= {p.cf, p.pt};
      do @(posedge clock); while (!req_tready);
      distort_point(p);
   endtask

   task automatic settle_input();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
   endtask

   // wait out every pending row plus pipeline depth
   task automatic drain_rows();
      settle_input();
      while (rows_pending.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx < CSR_SPARE_LO) coeff_word[idx] = data;
   endtask

   task automatic load_coeffs(input logic [31:0] k1, input logic [31:0] k2,
                              input logic [31:0] k3, input logic [31:0] p1,
                              input logic [31:0] p2);
      write_csr(CSR_K1, k1);
      write_csr(CSR_K2, k2);
      write_csr(CSR_K3, k3);
      write_csr(CSR_P1, p1);
      write_csr(CSR_P2, p2);
      write_csr(3'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)), $urandom);
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coeff(input int style);
      case (style)
         0: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
         1: return $urandom;
         default: return ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
   endfunction

   function automatic point_vec_type rand_point();
      point_vec_type p;
      if ($urandom_range(4) == 0) begin
         p.x = $urandom;
         p.y = $urandom;
      end else begin
         // mostly within the unit square, as undistortion maps see
         p.x = 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
         p.y = 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
      end
      p.pt = 1'($urandom_range(1));
      p.cf = ($urandom_range(2) == 0);
      p.typed = 1'b0;
      p.eu = '0;
      p.ev = '0;
      return p;
   endfunction

   // with all coefficients zero the point passes through: u = x, v = y in Q.32
   point_vec_type zero_coeff_vecs[] = '{
      '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 48'h0, 48'h0},
      '{32'h1000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b1, 48'h0001_0000_0000, 48'h0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 1'b1,
        48'h0007_FFFF_FFF0, 48'hFFF8_0000_0000},
      '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1,
        48'hFFF8_0000_0000, 48'h0007_FFFF_FFF0},
      '{32'hF000_0000, 32'h1000_0000, 1'b1, 1'b1, 1'b1,
        48'hFFFF_0000_0000, 48'h0001_0000_0000},
      '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 48'h10, 48'hFFFF_FFFF_FFF0}
   };

   point_vec_type edge_vecs[] = '{
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 48'h0, 48'h0},
      '{32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1, 1'b0, 48'h0, 48'h0},
      '{32'h1000_0000, 32'hF000_0000, 1'b1, 1'b1, 1'b0, 48'h0, 48'h0},
      '{32'h0800_0000, 32'h0400_0000, 1'b1, 1'b0, 1'b0, 48'h0, 48'h0},
      '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 48'h0, 48'h0},
      '{32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 48'h0, 48'h0}
   };

   initial begin
      point_vec_type p;
      int style;
      for (int i = 0; i < 5; i++) coeff_word[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (zero_coeff_vecs[i]) send_point(zero_coeff_vecs[i]);
      drain_rows();
      load_coeffs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF);
      foreach (edge_vecs[i]) send_point(edge_vecs[i]);
      drain_rows();
      load_coeffs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000);
      foreach (edge_vecs[i]) send_point(edge_vecs[i]);
      drain_rows();

      for (int ph = 0; ph < 6; ph++) begin
         style = ph % 3;
         load_coeffs(rand_coeff(style), rand_coeff(style), rand_coeff(style),
                     rand_coeff(style), rand_coeff(style));
         if (ph == 1) hold_asked++;
         for (int n = 0; n < 57; n++) begin
            p = rand_point();
            send_point(p);
            // sender pause until everything is back
            if (ph == 2 && n == 30) begin
               settle_input();
               while (rows_pending.size() != 0) @(posedge clock);
            end
         end
         drain_rows();
      end

      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+hdl
hdl/rtld_pkg.sv
hdl/rtld_qmul.sv
hdl/radial_tangential_lens_distort_top.sv
tb/tb_radial_tangential_lens_distort_top.sv
